### rtl/core/lfpd_pkg.sv
// shared types and constants for the line follower pid drive block
package lfpd_pkg;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;

  localparam logic [2:0] REG_KP_GAIN    = 3'd0;
  localparam logic [2:0] REG_KI_GAIN    = 3'd1;
  localparam logic [2:0] REG_KD_GAIN    = 3'd2;
  localparam logic [2:0] REG_BASE_SPEED = 3'd3;
  localparam logic [2:0] REG_STOP_MARKS = 3'd4;

  localparam logic [15:0] KP_GAIN_RESET    = 16'd256;
  localparam logic [15:0] KI_GAIN_RESET    = 16'd0;
  localparam logic [15:0] KD_GAIN_RESET    = 16'd0;
  localparam logic [9:0]  BASE_SPEED_RESET = 10'd0;
  localparam logic [3:0]  STOP_MARKS_RESET = 4'd12;

  localparam logic [12:0] CENTER_POS = 13'd3500;
  localparam logic [12:0] MAX_POS    = 13'd7000;
  localparam logic [9:0]  DUTY_MAX   = 10'd1023;
  localparam logic [3:0]  MARKS_MAX  = 4'd15;

  typedef struct packed {
    logic [1:0]  mode;
    logic [12:0] line_position;
    logic        marker_level;
  } req_t;

  typedef struct packed {
    logic [9:0] motor_a;
    logic [9:0] motor_b;
    logic       active;
    logic [3:0] marks_seen;
  } res_t;

  typedef struct packed {
    logic [15:0] kp_gain;
    logic [15:0] ki_gain;
    logic [15:0] kd_gain;
    logic [9:0]  base_speed;
    logic [3:0]  stop_marks;
  } cfg_t;

endpackage

### rtl/core/lfpd_cfg.sv
// apb register file holding the gains, base speed and stop mark count
module lfpd_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output lfpd_pkg::cfg_t     cfg
);

  logic       wr_en;
  logic [2:0] reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign wr_en     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp_gain    <= lfpd_pkg::KP_GAIN_RESET;
      cfg.ki_gain    <= lfpd_pkg::KI_GAIN_RESET;
      cfg.kd_gain    <= lfpd_pkg::KD_GAIN_RESET;
      cfg.base_speed <= lfpd_pkg::BASE_SPEED_RESET;
      cfg.stop_marks <= lfpd_pkg::STOP_MARKS_RESET;
    end else if (wr_en) begin
      case (reg_index)
        lfpd_pkg::REG_KP_GAIN:    cfg.kp_gain    <= pwdata[15:0];
        lfpd_pkg::REG_KI_GAIN:    cfg.ki_gain    <= pwdata[15:0];
        lfpd_pkg::REG_KD_GAIN:    cfg.kd_gain    <= pwdata[15:0];
        lfpd_pkg::REG_BASE_SPEED: cfg.base_speed <= pwdata[9:0];
        lfpd_pkg::REG_STOP_MARKS: cfg.stop_marks <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      lfpd_pkg::REG_KP_GAIN:    prdata = {16'd0, cfg.kp_gain};
      lfpd_pkg::REG_KI_GAIN:    prdata = {16'd0, cfg.ki_gain};
      lfpd_pkg::REG_KD_GAIN:    prdata = {16'd0, cfg.kd_gain};
      lfpd_pkg::REG_BASE_SPEED: prdata = {22'd0, cfg.base_speed};
      lfpd_pkg::REG_STOP_MARKS: prdata = {28'd0, cfg.stop_marks};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

### rtl/core/line_follow_pid_drive.sv
// line follower pid drive: top level with request state update and drive pipeline
// requests pass input, stage 1, stage 2, result regs; one per cycle unless stalled
// stages: input register, state update, three gain multiplies, sum/shift/saturate
// the controller state loop closes within the state update stage
// rst clears state, registers to their reset values and all pipeline valids
module line_follow_pid_drive #(
  parameter int GAIN_FRAC_BITS = 8,
  parameter int INTEGRAL_BITS  = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  lfpd_pkg::req_t     req,
  output logic               res_valid,
  input  logic               res_stall,
  output lfpd_pkg::res_t     res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int IB    = INTEGRAL_BITS;
  localparam int MI_W  = IB + 17;
  localparam int SUM_W = IB + 19;

  lfpd_pkg::cfg_t cfg;

  lfpd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // pipeline control
  logic v0, v1, v2;
  logic ready0, ready1, ready2, ready3;

  assign ready3    = !res_valid || !res_stall;
  assign ready2    = !v2 || ready3;
  assign ready1    = !v1 || ready2;
  assign ready0    = !v0 || ready1;
  assign req_stall = !ready0;

  // controller state
  logic signed [IB-1:0] integral_sum, integral_sum_next;
  logic signed [12:0]   previous_error, previous_error_next;
  logic                 marker_previous, marker_previous_next;
  logic [3:0]           marker_count, marker_count_next;
  logic                 running, running_next;

  // stage 0: input register
  lfpd_pkg::req_t req0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (ready0) begin
      v0 <= req_valid;
    end
    if (ready0 && req_valid) begin
      req0 <= req;
    end
  end

  // state update
  logic [12:0]          pos_c;
  logic [13:0]          err_w;
  logic signed [12:0]   err;
  logic signed [IB:0]   acc;
  logic signed [IB-1:0] acc_sat;
  logic signed [13:0]   d;
  logic [3:0]           cnt_n;
  logic                 run_end;
  logic                 tick_run;
  logic                 go0;

  assign go0 = v0 && ready1;

  always_comb begin
    pos_c    = (req0.line_position > lfpd_pkg::MAX_POS) ? lfpd_pkg::MAX_POS
                                                        : req0.line_position;
    err_w    = {1'b0, pos_c} - {1'b0, lfpd_pkg::CENTER_POS};
    err      = $signed(err_w[12:0]);
    acc      = (IB+1)'(integral_sum) + (IB+1)'(err);
    acc_sat  = (acc[IB] != acc[IB-1]) ? {acc[IB], {(IB-1){~acc[IB]}}} : acc[IB-1:0];
    d        = 14'(err) - 14'(previous_error);
    cnt_n    = marker_count;
    if (req0.marker_level && !marker_previous && marker_count != lfpd_pkg::MARKS_MAX) begin
      cnt_n = marker_count + 4'd1;
    end
    run_end  = cnt_n >= cfg.stop_marks;
    tick_run = (req0.mode == lfpd_pkg::MODE_TICK) && running;

    integral_sum_next    = integral_sum;
    previous_error_next  = previous_error;
    marker_previous_next = marker_previous;
    marker_count_next    = marker_count;
    running_next         = running;
    case (req0.mode)
      lfpd_pkg::MODE_START: begin
        running_next      = 1'b1;
        integral_sum_next = '0;
        marker_count_next = 4'd0;
      end
      lfpd_pkg::MODE_STOP: begin
        running_next = 1'b0;
      end
      lfpd_pkg::MODE_TICK: begin
        if (running) begin
          integral_sum_next    = acc_sat;
          previous_error_next  = err;
          marker_previous_next = req0.marker_level;
          marker_count_next    = cnt_n;
          running_next         = !run_end;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum    <= '0;
      previous_error  <= '0;
      marker_previous <= 1'b0;
      marker_count    <= 4'd0;
      running         <= 1'b0;
    end else if (go0) begin
      integral_sum    <= integral_sum_next;
      previous_error  <= previous_error_next;
      marker_previous <= marker_previous_next;
      marker_count    <= marker_count_next;
      running         <= running_next;
    end
  end

  // stage 1: error terms
  logic signed [12:0]   err1;
  logic signed [IB-1:0] integ1;
  logic signed [13:0]   d1;
  logic                 drive1, active1;
  logic [3:0]           marks1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= v0;
    end
    if (go0) begin
      err1    <= err;
      integ1  <= acc_sat;
      d1      <= d;
      drive1  <= tick_run && !run_end;
      active1 <= running_next;
      marks1  <= marker_count_next;
    end
  end

  // stage 2: gain products
  logic signed [29:0]     mp, mp2;
  logic signed [MI_W-1:0] mi, mi2;
  logic signed [30:0]     md, md2;
  logic                   drive2, active2;
  logic [3:0]             marks2;

  assign mp = $signed({1'b0, cfg.kp_gain}) * err1;
  assign mi = $signed({1'b0, cfg.ki_gain}) * integ1;
  assign md = $signed({1'b0, cfg.kd_gain}) * d1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
    if (v1 && ready2) begin
      mp2     <= mp;
      mi2     <= mi;
      md2     <= md;
      drive2  <= drive1;
      active2 <= active1;
      marks2  <= marks1;
    end
  end

  // stage 3: sum, floor shift, saturate
  logic signed [SUM_W-1:0] sum, term;
  logic signed [SUM_W:0]   a_w, b_w, duty_max_w;
  logic [9:0]              a_sat, b_sat;
  lfpd_pkg::res_t          res_next;

  always_comb begin
    sum        = SUM_W'(mp2) + SUM_W'(mi2) + SUM_W'(md2);
    term       = sum >>> GAIN_FRAC_BITS;
    duty_max_w = $signed((SUM_W+1)'(lfpd_pkg::DUTY_MAX));
    a_w        = $signed((SUM_W+1)'(cfg.base_speed)) - (SUM_W+1)'(term);
    b_w        = $signed((SUM_W+1)'(cfg.base_speed)) + (SUM_W+1)'(term);
    if (a_w < 0) begin
      a_sat = 10'd0;
    end else if (a_w > duty_max_w) begin
      a_sat = lfpd_pkg::DUTY_MAX;
    end else begin
      a_sat = a_w[9:0];
    end
    if (b_w < 0) begin
      b_sat = 10'd0;
    end else if (b_w > duty_max_w) begin
      b_sat = lfpd_pkg::DUTY_MAX;
    end else begin
      b_sat = b_w[9:0];
    end
    res_next.motor_a    = drive2 ? a_sat : 10'd0;
    res_next.motor_b    = drive2 ? b_sat : 10'd0;
    res_next.active     = active2;
    res_next.marks_seen = marks2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ready3) begin
      res_valid <= v2;
    end
    if (v2 && ready3) begin
      res <= res_next;
    end
  end

  a_idle_motors: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.active |-> res.motor_a == 10'd0 && res.motor_b == 10'd0)
    else $error("motors driven while not running");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    go0 && req0.mode == lfpd_pkg::MODE_START |=>
      running && integral_sum == '0 && marker_count == 4'd0)
    else $error("start did not reset the run state");

  a_stage_move: assert property (@(posedge clk) disable iff (rst)
    go0 |=> v1)
    else $error("request lost between state update and multiply stages");

  a_out_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> !req_stall)
    else $error("requests stalled with the result register empty");

endmodule
